@@ hw/rtl/rar_pkg.sv @@
// Shared types and constants for the rational arithmetic reduction core.
// Holds operation codes, multiplier step codes and controller/datapath structs.
// No dependencies.
`default_nettype none

package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    // operation codes carried on the kind field
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;
    localparam logic [1:0] KIND_DIV = 2'd3;

    // which product the shared multiplier forms
    typedef enum logic [1:0] {
        MUL_NUM_A = 2'd0,
        MUL_NUM_B = 2'd1,
        MUL_DEN   = 2'd2
    } mul_step_t;

    typedef struct packed {
        logic      load;
        logic      mul_en;
        mul_step_t mul_step;
        logic      sum_en;
        logic      gcd_en;
        logic      shl_en;
        logic      div_start;
        logic      div_start_den;
        logic      div_en;
        logic      div_sel_den;
        logic      out_load;
    } rar_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic gcd_done;
        logic k_zero;
        logic div_last;
    } rar_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/rar_ctrl.sv @@
// Controller state machine for the rational arithmetic reduction core.
// Sequences multiply, combine, GCD, rescale and divide steps; owns the handshakes.
// Depends on rar_pkg.
`default_nettype none

module rar_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire rar_pkg::rar_sts_t sts,
    output rar_pkg::rar_cmd_t      cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MUL0 = 10'b0000000010,
        S_MUL1 = 10'b0000000100,
        S_MUL2 = 10'b0000001000,
        S_SUM  = 10'b0000010000,
        S_GCD  = 10'b0000100000,
        S_SHL  = 10'b0001000000,
        S_DIVN = 10'b0010000000,
        S_DIVD = 10'b0100000000,
        S_DONE = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_step = rar_pkg::MUL_NUM_A;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = rar_pkg::MUL_NUM_A;
                state_next   = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = rar_pkg::MUL_NUM_B;
                state_next   = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = rar_pkg::MUL_DEN;
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = sts.den_zero ? S_DONE : S_GCD;
            end
            S_GCD:
            begin
                cmd.gcd_en = 1'b1;
                if (sts.gcd_done)
                begin
                    state_next = S_SHL;
                end
            end
            S_SHL:
            begin
                if (!sts.k_zero)
                begin
                    cmd.shl_en = 1'b1;
                end
                else
                begin
                    cmd.div_start     = 1'b1;
                    cmd.div_start_den = 1'b0;
                    state_next        = S_DIVN;
                end
            end
            S_DIVN:
            begin
                cmd.div_en      = 1'b1;
                cmd.div_sel_den = 1'b0;
                if (sts.div_last)
                begin
                    // chain straight into the denominator division
                    cmd.div_start     = 1'b1;
                    cmd.div_start_den = 1'b1;
                    state_next        = S_DIVD;
                end
            end
            S_DIVD:
            begin
                cmd.div_en      = 1'b1;
                cmd.div_sel_den = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rar_dp.sv @@
// Datapath for the rational arithmetic reduction core: shared multiplier,
// binary GCD unit, shared restoring divider and the result register.
// Depends on rar_pkg.
`default_nettype none

module rar_dp #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire rar_pkg::rar_cmd_t                 cmd,
    output rar_pkg::rar_sts_t                      sts,
    input  wire logic        [1:0]                 kind,
    input  wire logic signed [OPERAND_WIDTH-1:0]   a_num,
    input  wire logic signed [OPERAND_WIDTH-1:0]   a_den,
    input  wire logic signed [OPERAND_WIDTH-1:0]   b_num,
    input  wire logic signed [OPERAND_WIDTH-1:0]   b_den,
    output logic signed      [2*OPERAND_WIDTH:0]   result_num,
    output logic signed      [2*OPERAND_WIDTH-1:0] result_den,
    output logic                                   zero_den
);

    localparam int W     = OPERAND_WIDTH;
    localparam int P_W   = 2 * OPERAND_WIDTH;
    localparam int N_W   = 2 * OPERAND_WIDTH + 1;
    localparam int K_W   = $clog2(P_W + 1);
    localparam int CNT_W = $clog2(P_W);

    // operand capture
    logic        [1:0]   kind_reg;
    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;

    // products
    logic signed [W-1:0]   mul_x, mul_y;
    logic signed [P_W-1:0] mul_p;
    logic signed [P_W-1:0] prod_a_reg, prod_b_reg, den_reg;

    // combine
    logic signed [N_W-1:0] ext_a, ext_b, num_c, num_neg_c;
    logic signed [P_W-1:0] den_neg_c;
    logic                  num_neg_reg, den_neg_reg, zero_reg;
    logic        [P_W-1:0] nm_reg, dm_reg;

    // binary GCD
    logic [P_W-1:0] u_reg, v_reg, g_reg;
    logic [K_W-1:0] k_reg;
    logic           gcd_done;

    // restoring divider
    logic [P_W-1:0]   rem_reg, dq_reg, rem_next, dq_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [P_W:0]     div_sh, div_diff;
    logic             div_ge, div_last;
    logic [P_W-1:0]   qn_reg, qd_reg;

    // output
    logic signed [N_W-1:0] result_num_reg, rn_mag;
    logic signed [P_W-1:0] result_den_reg;
    logic                  zero_den_reg;

    always_comb
    begin
        case (cmd.mul_step)
            rar_pkg::MUL_NUM_A:
            begin
                mul_x = an_reg;
                mul_y = (kind_reg == rar_pkg::KIND_MUL) ? bn_reg : bd_reg;
            end
            rar_pkg::MUL_NUM_B:
            begin
                mul_x = bn_reg;
                mul_y = ad_reg;
            end
            rar_pkg::MUL_DEN:
            begin
                mul_x = ad_reg;
                mul_y = (kind_reg == rar_pkg::KIND_DIV) ? bn_reg : bd_reg;
            end
            default:
            begin
                mul_x = an_reg;
                mul_y = bd_reg;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    assign ext_a = {prod_a_reg[P_W-1], prod_a_reg};
    assign ext_b = {prod_b_reg[P_W-1], prod_b_reg};

    always_comb
    begin
        case (kind_reg)
            rar_pkg::KIND_ADD: num_c = ext_a + ext_b;
            rar_pkg::KIND_SUB: num_c = ext_a - ext_b;
            default:           num_c = ext_a;
        endcase
    end

    assign num_neg_c = -num_c;
    assign den_neg_c = -den_reg;

    assign gcd_done = (u_reg == '0) || (v_reg == '0);

    // one restoring step: shift in the next dividend bit, trial subtract
    assign div_sh   = {rem_reg, dq_reg[P_W-1]};
    assign div_diff = div_sh - {1'b0, g_reg};
    assign div_ge   = (div_sh >= {1'b0, g_reg});
    assign rem_next = div_ge ? div_diff[P_W-1:0] : div_sh[P_W-1:0];
    assign dq_next  = {dq_reg[P_W-2:0], div_ge};
    assign div_last = (cnt_reg == CNT_W'(P_W - 1));

    assign rn_mag = {1'b0, qn_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            an_reg   <= a_num;
            ad_reg   <= a_den;
            bn_reg   <= b_num;
            bd_reg   <= b_den;
        end

        if (cmd.mul_en)
        begin
            case (cmd.mul_step)
                rar_pkg::MUL_NUM_A: prod_a_reg <= mul_p;
                rar_pkg::MUL_NUM_B: prod_b_reg <= mul_p;
                rar_pkg::MUL_DEN:   den_reg    <= mul_p;
                default:            prod_a_reg <= mul_p;
            endcase
        end

        if (cmd.sum_en)
        begin
            num_neg_reg <= num_c[N_W-1];
            den_neg_reg <= den_reg[P_W-1];
            zero_reg    <= (den_reg == '0);
            nm_reg      <= num_c[N_W-1] ? num_neg_c[P_W-1:0] : num_c[P_W-1:0];
            dm_reg      <= den_reg[P_W-1] ? den_neg_c : den_reg;
            u_reg       <= num_c[N_W-1] ? num_neg_c[P_W-1:0] : num_c[P_W-1:0];
            v_reg       <= den_reg[P_W-1] ? den_neg_c : den_reg;
            k_reg       <= '0;
        end
        else if (cmd.gcd_en)
        begin
            if (gcd_done)
            begin
                g_reg <= u_reg | v_reg;
            end
            else if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + K_W'(1);
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg >= v_reg)
            begin
                u_reg <= u_reg - v_reg;
            end
            else
            begin
                v_reg <= v_reg - u_reg;
            end
        end
        else if (cmd.shl_en)
        begin
            // restore the common power of two
            g_reg <= g_reg << 1;
            k_reg <= k_reg - K_W'(1);
        end

        if (cmd.div_start)
        begin
            rem_reg <= '0;
            cnt_reg <= '0;
            dq_reg  <= cmd.div_start_den ? dm_reg : nm_reg;
        end
        else if (cmd.div_en)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end

        if (cmd.div_en && div_last)
        begin
            if (cmd.div_sel_den)
            begin
                qd_reg <= dq_next;
            end
            else
            begin
                qn_reg <= dq_next;
            end
        end

        if (cmd.out_load)
        begin
            zero_den_reg <= zero_reg;
            if (zero_reg)
            begin
                result_num_reg <= '0;
                result_den_reg <= '0;
            end
            else
            begin
                result_num_reg <= num_neg_reg ? -rn_mag : rn_mag;
                result_den_reg <= den_neg_reg ? -$signed(qd_reg) : $signed(qd_reg);
            end
        end
    end

    assign sts.den_zero = (den_reg == '0);
    assign sts.gcd_done = gcd_done;
    assign sts.k_zero   = (k_reg == '0);
    assign sts.div_last = div_last;

    assign result_num = result_num_reg;
    assign result_den = result_den_reg;
    assign zero_den   = zero_den_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rational_arith_reduce_core.sv @@
// Top level of the rational arithmetic reduction core.
// Joins the controller (rar_ctrl) and the datapath (rar_dp); uses rar_pkg.
// A checker (rar_checker) binds to this module from its own file.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | to core   | in_valid / in_ready   | kind, a_num, a_den, b_num, b_den
//  out     | from core | out_valid / out_ready | result_num, result_den, zero_den
//
// Steps: one transaction at a time; capture, 3 products, combine, a binary GCD
// loop, a rescale that restores the common power of two, the numerator and then the
// denominator division on the shared divider, and the load of the result register.
// A zero denominator skips GCD and division and goes straight from combine to the load.
// Reset: rst_n is asynchronous; it clears the controller state and out_valid.
// Stalls: a waiting result still lets the next transaction in; that one holds in S_DONE.
`default_nettype none

module rational_arith_reduce_core #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic        [1:0]                 kind,
    input  wire logic signed [OPERAND_WIDTH-1:0]   a_num,
    input  wire logic signed [OPERAND_WIDTH-1:0]   a_den,
    input  wire logic signed [OPERAND_WIDTH-1:0]   b_num,
    input  wire logic signed [OPERAND_WIDTH-1:0]   b_den,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed      [2*OPERAND_WIDTH:0]   result_num,
    output logic signed      [2*OPERAND_WIDTH-1:0] result_den,
    output logic                                   zero_den
);

    // command and status between the sequencer and the arithmetic
    rar_pkg::rar_cmd_t cmd;
    rar_pkg::rar_sts_t sts;

    // sequencer: owns both handshakes and the step order
    rar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic: multiplier, GCD, divider and the result register
    rar_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .sts        (sts),
        .kind       (kind),
        .a_num      (a_num),
        .a_den      (a_den),
        .b_num      (b_num),
        .b_den      (b_den),
        .result_num (result_num),
        .result_den (result_den),
        .zero_den   (zero_den)
    );

endmodule

`default_nettype wire

@@ hw/rtl/rar_checker.sv @@
// Port-level checker for rational_arith_reduce_core, bound to the top level.
// Watches the handshakes and result fields over time; uses no package items.
`default_nettype none

module rar_checker #(
    parameter int OPERAND_WIDTH = 16
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic signed [2*OPERAND_WIDTH:0]   result_num,
    input wire logic signed [2*OPERAND_WIDTH-1:0] result_den,
    input wire logic                              zero_den
);

    localparam int DEN_W = 2 * OPERAND_WIDTH;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_num)
            && $stable(result_den) && $stable(zero_den))
        else $error("result changed while stalled");

    // one transaction at a time: ready drops after an accept
    a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_den |-> result_num == '0 && result_den == '0)
        else $error("zero denominator flag with nonzero fields");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_den |-> result_den != '0)
        else $error("zero reduced denominator without flag");

    a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_den && result_num == '0
            |-> result_den == DEN_W'(1) || result_den == {DEN_W{1'b1}})
        else $error("zero numerator not reduced to unit denominator");

endmodule

bind rational_arith_reduce_core rar_checker #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
) u_rar_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_num (result_num),
    .result_den (result_den),
    .zero_den   (zero_den)
);

`default_nettype wire
